@@ src/sirc_ir_frame_decoder_assert.svh @@
// assertion macros shared by the ir frame decoder rtl
// no dependencies; the files that check behavior include this header
`ifndef SIRC_IR_FRAME_DECODER_ASSERT_SVH
`define SIRC_IR_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define SIRC_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition now implies consequence at the next clock edge
`define SIRC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SIRC_ASSERT_HOLDS(label, clk, rst, prop, msg)
`define SIRC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ src/sirc_pkg.sv @@
// shared types, widths, codes and helpers of the ir frame decoder
// no dependencies; used by sirc_match and sirc_ir_frame_decoder
package sirc_pkg;

   // payload and state widths
   localparam int DUR_W       = 16;
   localparam int MAX_BITS    = 20;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 3;
   localparam int CMD_W       = 7;
   localparam int ADDR_W      = 13;
   localparam int BIT_COUNT_W = 5;
   localparam int POS_W       = 6;
   localparam int BITS_W      = $clog2(MAX_BITS + 1);
   localparam int ERR_W       = 3;

   // configuration widths
   localparam int UNIT_W    = 8;
   localparam int TOL_W     = 7;
   localparam int EXCESS_W  = 8;
   localparam int GAP_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // result beat packing
   localparam int RSP_FIELDS_W = CMD_W + ADDR_W + BIT_COUNT_W + 1;
   localparam int RSP_DATA_W   = 8 * ((RSP_FIELDS_W + 7) / 8);

   // window arithmetic widths
   localparam int PCT_W  = 8;
   localparam int PROD_W = UNIT_W + PCT_W;
   localparam int SUM_W  = DUR_W + 1;
   localparam int V100_W = SUM_W + 7;

   localparam logic [TOL_W-1:0] TOL_MAX  = TOL_W'(99);
   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

   // frame position bookkeeping
   localparam logic [POS_W-1:0] POS_IDLE    = '0;
   localparam logic [POS_W-1:0] POS_GAP     = POS_W'(1);
   localparam logic [POS_W-1:0] POS_HDR_SPC = POS_W'(2);
   localparam logic [POS_W-1:0] POS_MAX     = POS_W'(63);
   localparam logic [POS_W-1:0] POS_END_12  = POS_W'(2 * 12 + 2);
   localparam logic [POS_W-1:0] POS_END_15  = POS_W'(2 * 15 + 2);
   localparam logic [POS_W-1:0] POS_END_20  = POS_W'(2 * 20 + 2);
   localparam int BITS_CAP = (MAX_BITS < 31) ? MAX_BITS : 31;

   // input action codes
   localparam logic [ACTION_W-1:0] ACT_GAP   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SPACE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_END   = 2'd3;

   // result status codes, in rank order
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HDR_MARK  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LENGTH    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HDR_SPACE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_BIT   = 3'd4;

   // error flag bit positions
   localparam int ERR_HDR_MARK  = 0;
   localparam int ERR_HDR_SPACE = 1;
   localparam int ERR_BIT       = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCESS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 2'd3;

   // duration matches against the nominal unit counts
   typedef struct packed {
      logic mark4;
      logic mark2;
      logic mark1;
      logic space1;
   } match_type;

   // v * 100 by shift and add
   function automatic logic [V100_W-1:0] times100(input logic [SUM_W-1:0] v);
      logic [V100_W-1:0] w;
      w = V100_W'(v);
      return (w << 6) + (w << 5) + (w << 2);
   endfunction

   // v in [floor(lo/100), floor(hi/100) + 1], with hi given as hi + 100
   function automatic logic in_window(input logic [V100_W-1:0] v100,
                                      input logic [V100_W-1:0] lo,
                                      input logic [V100_W-1:0] hi);
      return ((v100 + V100_W'(PCT_FULL - 8'd1)) >= lo) && (v100 <= hi);
   endfunction

endpackage

@@ src/sirc_ir_frame_decoder.sv @@
// top level of the ir frame decoder: stream ports, config, frame state
// depends on sirc_pkg, sirc_match and sirc_ir_frame_decoder_assert.svh
`include "sirc_ir_frame_decoder_assert.svh"

// Decodes 12, 15 or 20 bit pulse-width ir frames from measured durations.
// Each req beat carries an action in tuser (leading gap, mark, space, frame
// end) and a duration in ticks in tdata. A leading gap opens a frame; the
// frame end beat yields exactly one rsp beat with status in tuser and
// command, address, bit count and repeat flag in tdata. Beats with no frame
// open are dropped silently. The block takes one beat every clock cycle,
// but only a frame end beat stalls, while an earlier result waits on rsp.
// A beat goes into an input register, is matched and folded into the frame
// state from there, and a frame end beat then loads its result into the rsp
// register. The match thresholds are registered from the config registers,
// so a csr write reaches them through the config and threshold registers.
module sirc_ir_frame_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // config write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sirc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sirc_pkg::CSR_DATA_W-1:0]   csr_data,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sirc_pkg::DUR_W-1:0]        req_tdata,   // duration
   input  logic [sirc_pkg::ACTION_W-1:0]     req_tuser,   // action
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // command, address, bit_count, is_repeat, zero fill
   output logic [sirc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [sirc_pkg::STATUS_W-1:0]     rsp_tuser    // status
);
   import sirc_pkg::*;

   // config registers
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic [EXCESS_W-1:0] excess_ff, excess_in;
   logic [GAP_W-1:0]    repeat_gap_ff, repeat_gap_in;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0] in_action_ff, in_action_in;
   logic [DUR_W-1:0]    in_dur_ff, in_dur_in;

   // frame state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [MAX_BITS-1:0] shift_ff, shift_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   logic                rep_ff, rep_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [CMD_W-1:0]       rsp_cmd_ff, rsp_cmd_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [BIT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_rep_ff, rsp_rep_in;

   match_type        match;
   logic             req_beat;
   logic             csr_beat;
   logic             is_end;
   logic             advance;
   logic             fire;
   logic             rsp_load;
   logic             len_ok;
   logic             data_bit;
   logic [STATUS_W-1:0] status;

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid & csr_ready;

   // config writes
   always_comb begin
      unit_in       = unit_ff;
      tol_in        = tol_ff;
      excess_in     = excess_ff;
      repeat_gap_in = repeat_gap_ff;
      if (csr_beat) begin
         case (csr_index)
            CSR_UNIT:   unit_in       = csr_data[UNIT_W-1:0];
            CSR_TOL:    tol_in        = csr_data[TOL_W-1:0];
            CSR_EXCESS: excess_in     = csr_data[EXCESS_W-1:0];
            CSR_REPEAT: repeat_gap_in = csr_data[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // window matching on the registered duration
   sirc_match u_match (
      .clock             (clock),
      .unit_ticks        (unit_ff),
      .tolerance_pct     (tol_ff),
      .mark_excess_ticks (excess_ff),
      .duration          (in_dur_ff),
      .match             (match)
   );

   // handshake: only a frame end beat waits on a full result register
   always_comb begin
      is_end     = (in_action_ff == ACT_END) && (pos_ff != POS_IDLE);
      advance    = !(is_end && rsp_valid_ff && !rsp_tready);
      fire       = in_valid_ff && advance;
      req_tready = !in_valid_ff || advance;
      req_beat   = req_tvalid && req_tready;
   end

   // input register next value
   always_comb begin
      in_action_in = in_action_ff;
      in_dur_in    = in_dur_ff;
      if (req_beat) begin
         in_valid_in  = 1'b1;
         in_action_in = req_tuser;
         in_dur_in    = req_tdata;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // result status by rank
   always_comb begin
      len_ok = (pos_ff == POS_END_12) || (pos_ff == POS_END_15) || (pos_ff == POS_END_20);
      if (err_ff[ERR_HDR_MARK])       status = ST_HDR_MARK;
      else if (!len_ok)               status = ST_LENGTH;
      else if (err_ff[ERR_HDR_SPACE]) status = ST_HDR_SPACE;
      else if (err_ff[ERR_BIT])       status = ST_BAD_BIT;
      else                            status = ST_OK;
   end

   // frame state update
   always_comb begin
      pos_in   = pos_ff;
      shift_in = shift_ff;
      err_in   = err_ff;
      rep_in   = rep_ff;
      bits_in  = bits_ff;
      rsp_load = 1'b0;
      data_bit = match.mark2;
      if (fire) begin
         if (in_action_ff == ACT_GAP) begin
            pos_in   = POS_GAP;
            shift_in = '0;
            err_in   = ERR_W'(1) << ERR_HDR_MARK;
            rep_in   = GAP_W'(in_dur_ff) < repeat_gap_ff;
            bits_in  = '0;
         end else if (is_end) begin
            pos_in   = POS_IDLE;
            rsp_load = 1'b1;
         end else if ((pos_ff != POS_IDLE) && (pos_ff != POS_MAX)) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_GAP) begin
               // header mark
               if (match.mark4) err_in[ERR_HDR_MARK] = 1'b0;
            end else if (pos_ff == POS_HDR_SPC) begin
               // header space
               if (!match.space1) err_in[ERR_HDR_SPACE] = 1'b1;
            end else if (pos_ff[0]) begin
               // data mark, two units wins over one
               if (!match.mark2 && !match.mark1) err_in[ERR_BIT] = 1'b1;
               if (bits_ff < BITS_W'(BITS_CAP)) begin
                  for (int i = 0; i < MAX_BITS; i++) begin
                     if (bits_ff == BITS_W'(i) && data_bit) shift_in[i] = 1'b1;
                  end
                  bits_in = bits_ff + BITS_W'(1);
               end
            end else begin
               // data space
               if (!match.space1) err_in[ERR_BIT] = 1'b1;
            end
         end
      end
   end

   // result register next value
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rep_in    = rsp_rep_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         if (status == ST_OK) begin
            rsp_cmd_in   = shift_ff[CMD_W-1:0];
            rsp_addr_in  = ADDR_W'(shift_ff >> CMD_W);
            rsp_count_in = BIT_COUNT_W'((pos_ff - POS_W'(1)) >> 1);
            rsp_rep_in   = rep_ff;
         end else begin
            rsp_cmd_in   = '0;
            rsp_addr_in  = '0;
            rsp_count_in = '0;
            rsp_rep_in   = 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_tready) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff       <= UNIT_W'(12);
         tol_ff        <= TOL_W'(25);
         excess_ff     <= EXCESS_W'(2);
         repeat_gap_ff <= GAP_W'(900);
         in_valid_ff   <= 1'b0;
         pos_ff        <= POS_IDLE;
         shift_ff      <= '0;
         err_ff        <= '0;
         rep_ff        <= 1'b0;
         bits_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unit_ff       <= unit_in;
         tol_ff        <= tol_in;
         excess_ff     <= excess_in;
         repeat_gap_ff <= repeat_gap_in;
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         shift_ff      <= shift_in;
         err_ff        <= err_in;
         rep_ff        <= rep_in;
         bits_ff       <= bits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_action_ff  <= in_action_in;
      in_dur_ff     <= in_dur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rep_ff    <= rsp_rep_in;
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_rep_ff, rsp_count_ff, rsp_addr_ff, rsp_cmd_ff});

   // checks
   `SIRC_ASSERT_HOLDS(a_ok_count, clock, reset,
      !(rsp_valid_ff && rsp_status_ff == ST_OK) || rsp_count_ff == BIT_COUNT_W'(12) ||
      rsp_count_ff == BIT_COUNT_W'(15) || rsp_count_ff == BIT_COUNT_W'(20),
      "ok result with a bit count other than 12, 15 or 20")
   `SIRC_ASSERT_HOLDS(a_err_zero, clock, reset,
      !(rsp_valid_ff && rsp_status_ff != ST_OK) ||
      (rsp_cmd_ff == '0 && rsp_addr_ff == '0 && rsp_count_ff == '0 && !rsp_rep_ff),
      "error result with nonzero payload")
   `SIRC_ASSERT_NEXT(a_end_closes, clock, reset, fire && is_end,
      pos_ff == POS_IDLE && rsp_valid_ff,
      "frame end did not close the frame and post a result")
   `SIRC_ASSERT_HOLDS(a_bits_cap, clock, reset, bits_ff <= BITS_W'(BITS_CAP),
      "data bit counter beyond capacity")

endmodule

@@ src/sirc_match.sv @@
// tolerance window matching of one duration against 1, 2 and 4 units
// depends on sirc_pkg; threshold registers reload every cycle from config
module sirc_match (
   input  logic                            clock,
   input  logic [sirc_pkg::UNIT_W-1:0]     unit_ticks,
   input  logic [sirc_pkg::TOL_W-1:0]      tolerance_pct,
   input  logic [sirc_pkg::EXCESS_W-1:0]   mark_excess_ticks,
   input  logic [sirc_pkg::DUR_W-1:0]      duration,
   output sirc_pkg::match_type             match
);
   import sirc_pkg::*;

   logic [TOL_W-1:0]  tol_clamp;
   logic [PCT_W-1:0]  pct_lo;
   logic [PCT_W-1:0]  pct_hi;
   logic [PROD_W-1:0] prod_lo;
   logic [PROD_W-1:0] prod_hi;

   logic [V100_W-1:0] lo1_in, lo2_in, lo4_in, hi1_in, hi2_in, hi4_in;
   logic [V100_W-1:0] lo1_ff, lo2_ff, lo4_ff, hi1_ff, hi2_ff, hi4_ff;

   logic [DUR_W-1:0]  mark_val;
   logic [SUM_W-1:0]  space_val;
   logic [V100_W-1:0] mark100;
   logic [V100_W-1:0] space100;

   // window bounds scaled by 100: lo = n*(100-tol), hi = n*(100+tol) + 100
   always_comb begin
      tol_clamp = (tolerance_pct > TOL_MAX) ? TOL_MAX : tolerance_pct;
      pct_lo    = PCT_FULL - PCT_W'(tol_clamp);
      pct_hi    = PCT_FULL + PCT_W'(tol_clamp);
      prod_lo   = PROD_W'(unit_ticks) * PROD_W'(pct_lo);
      prod_hi   = PROD_W'(unit_ticks) * PROD_W'(pct_hi);
      lo1_in    = V100_W'(prod_lo);
      lo2_in    = V100_W'(prod_lo) << 1;
      lo4_in    = V100_W'(prod_lo) << 2;
      hi1_in    = V100_W'(prod_hi) + V100_W'(PCT_FULL);
      hi2_in    = (V100_W'(prod_hi) << 1) + V100_W'(PCT_FULL);
      hi4_in    = (V100_W'(prod_hi) << 2) + V100_W'(PCT_FULL);
   end

   // threshold registers
   always_ff @(posedge clock) begin
      lo1_ff <= lo1_in;
      lo2_ff <= lo2_in;
      lo4_ff <= lo4_in;
      hi1_ff <= hi1_in;
      hi2_ff <= hi2_in;
      hi4_ff <= hi4_in;
   end

   // marks lose the receiver stretch, spaces gain it
   always_comb begin
      mark_val  = (duration >= DUR_W'(mark_excess_ticks))
                  ? duration - DUR_W'(mark_excess_ticks) : '0;
      space_val = SUM_W'(duration) + SUM_W'(mark_excess_ticks);
      mark100   = times100(SUM_W'(mark_val));
      space100  = times100(space_val);
      match.mark4  = in_window(mark100, lo4_ff, hi4_ff);
      match.mark2  = in_window(mark100, lo2_ff, hi2_ff);
      match.mark1  = in_window(mark100, lo1_ff, hi1_ff);
      match.space1 = in_window(space100, lo1_ff, hi1_ff);
   end

endmodule

@@ sim/sirc_ir_frame_decoder_tb.sv @@
// self-checking bench for sirc_ir_frame_decoder: directed and random pulse streams
// predicts each frame result in-bench and checks every rsp beat; depends on sirc_pkg
`timescale 1ns / 100ps

module sirc_ir_frame_decoder_tb;
   import sirc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int STRETCH_PULSES = 310;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DUR_W-1:0]    duration;
   } pulse_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [CMD_W-1:0]       command;
      logic [ADDR_W-1:0]      address;
      logic [BIT_COUNT_W-1:0] bit_count;
      logic                   is_repeat;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DUR_W-1:0]      req_tdata = '0;    // duration
   logic [ACTION_W-1:0]   req_tuser = '0;    // action

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // command, address, bit_count, is_repeat, zero fill
   logic [STATUS_W-1:0]   rsp_tuser;         // status

   sirc_ir_frame_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // bench copy of the config registers
   logic [UNIT_W-1:0]   unit_cfg   = UNIT_W'(12);
   logic [TOL_W-1:0]    tol_cfg    = TOL_W'(25);
   logic [EXCESS_W-1:0] excess_cfg = EXCESS_W'(2);
   logic [GAP_W-1:0]    repeat_cfg = GAP_W'(900);

   // bench copy of the frame state
   int                  frame_pos = 0;
   logic [MAX_BITS-1:0] data_bits = '0;
   logic [ERR_W-1:0]    err_flags = '0;
   logic                repeat_hit = 1'b0;
   int                  bits_taken = 0;

   pulse_type        pulse_q[$];
   frame_result_type frame_result_q[$];
   pulse_type        pulse_on_bus;
   frame_result_type want;

   int pulses_queued = 0;
   int pulses_taken = 0;
   int failures = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // duration inside the tolerance window of a nominal unit count
   function automatic bit in_tol_window(input longint v, input int units);
      longint nominal, tol, lo, hi;
      nominal = longint'(units) * longint'(unit_cfg);
      tol = (tol_cfg > TOL_MAX) ? longint'(TOL_MAX) : longint'(tol_cfg);
      lo = nominal * (100 - tol) / 100;
      hi = nominal * (100 + tol) / 100 + 1;
      return (v >= lo) && (v <= hi);
   endfunction

   // marks come in stretched, spaces shortened
   function automatic bit mark_hit(input longint d, input int units);
      if (d < longint'(excess_cfg))
         return in_tol_window(0, units);
      return in_tol_window(d - longint'(excess_cfg), units);
   endfunction

   function automatic bit space_hit(input longint d, input int units);
      return in_tol_window(d + longint'(excess_cfg), units);
   endfunction

   // fold one accepted pulse beat into the frame state, queue a result on frame end
   function automatic void decode_pulse(input pulse_type p);
      frame_result_type r;
      int               nb;
      bit               len_ok;
      bit               bit_val;
      longint           d;
      d = longint'(p.duration);
      if (p.action == ACT_GAP) begin
         frame_pos = 1;
         data_bits = '0;
         err_flags = '0;
         err_flags[ERR_HDR_MARK] = 1'b1;
         repeat_hit = (p.duration < repeat_cfg);
         bits_taken = 0;
      end else if (frame_pos == 0) begin
         // no frame open, beat dropped
      end else if (p.action == ACT_END) begin
         nb = (frame_pos - 1) / 2;
         len_ok = (frame_pos == int'(POS_END_12)) || (frame_pos == int'(POS_END_15))
                  || (frame_pos == int'(POS_END_20));
         r = '0;
         if (err_flags[ERR_HDR_MARK])
            r.status = ST_HDR_MARK;
         else if (!len_ok)
            r.status = ST_LENGTH;
         else if (err_flags[ERR_HDR_SPACE])
            r.status = ST_HDR_SPACE;
         else if (err_flags[ERR_BIT])
            r.status = ST_BAD_BIT;
         else begin
            r.status    = ST_OK;
            r.command   = data_bits[CMD_W-1:0];
            r.address   = ADDR_W'(data_bits >> CMD_W);
            r.bit_count = BIT_COUNT_W'(nb);
            r.is_repeat = repeat_hit;
         end
         frame_result_q.push_back(r);
         frame_pos = 0;
      end else if (frame_pos < int'(POS_MAX)) begin
         if (frame_pos == int'(POS_GAP)) begin
            if (mark_hit(d, 4))
               err_flags[ERR_HDR_MARK] = 1'b0;
         end else if (frame_pos == int'(POS_HDR_SPC)) begin
            if (!space_hit(d, 1))
               err_flags[ERR_HDR_SPACE] = 1'b1;
         end else if (frame_pos % 2 == 1) begin
            // data mark: a two-unit match wins over one unit
            if (mark_hit(d, 2))
               bit_val = 1'b1;
            else if (mark_hit(d, 1))
               bit_val = 1'b0;
            else begin
               bit_val = 1'b0;
               err_flags[ERR_BIT] = 1'b1;
            end
            if (bits_taken < BITS_CAP) begin
               data_bits[bits_taken] = bit_val;
               bits_taken++;
            end
         end else begin
            if (!space_hit(d, 1))
               err_flags[ERR_BIT] = 1'b1;
         end
         frame_pos++;
      end
   endfunction

   function automatic void check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, act_val);
         failures++;
      end
   endfunction

   // req driver: predicts at each accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_pulse(pulse_on_bus);
            pulses_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pulse_q.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               pulse_on_bus = pulse_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= pulse_on_bus.action;
               req_tdata  <= pulse_on_bus.duration;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor: compare each beat with the oldest predicted frame result
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_result_q.size() == 0) begin
               $error("rsp beat with no frame result pending, status %0d", rsp_tuser);
               failures++;
            end else begin
               want = frame_result_q.pop_front();
               check_field("status", int'(want.status), int'(rsp_tuser));
               check_field("command", int'(want.command), int'(rsp_tdata[CMD_W-1:0]));
               check_field("address", int'(want.address),
                           int'(rsp_tdata[CMD_W +: ADDR_W]));
               check_field("bit_count", int'(want.bit_count),
                           int'(rsp_tdata[CMD_W+ADDR_W +: BIT_COUNT_W]));
               check_field("is_repeat", int'(want.is_repeat),
                           int'(rsp_tdata[CMD_W+ADDR_W+BIT_COUNT_W]));
               check_field("zero_fill", 0, int'(rsp_tdata >> RSP_FIELDS_W));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_pulse(input logic [ACTION_W-1:0] action, input int duration);
      pulse_type p;
      p.action = action;
      p.duration = DUR_W'(duration);
      pulse_q.push_back(p);
      pulses_queued++;
   endtask

   // mark and space labels are interchangeable on the wire
   function automatic logic [ACTION_W-1:0] any_label();
      return ($urandom_range(1) == 1) ? ACT_MARK : ACT_SPACE;
   endfunction

   // any action code at all
   function automatic logic [ACTION_W-1:0] any_action();
      return ACTION_W'($urandom_range(0, 3));
   endfunction

   // duration near the nominal mark or space length, sometimes off anywhere
   function automatic int pulse_dur(input int units, input bit is_mark);
      int nominal, span, target, d, tol;
      tol = (tol_cfg > TOL_MAX) ? int'(TOL_MAX) : int'(tol_cfg);
      nominal = units * int'(unit_cfg);
      span = nominal * tol / 100;
      target = is_mark ? nominal + int'(excess_cfg) : nominal - int'(excess_cfg);
      d = target + int'($urandom_range(0, 2 * span + 1)) - span;
      if ($urandom_range(31) == 0)
         d = int'($urandom_range(0, 65535));
      if (d < 0)
         d = 0;
      if (d > 65535)
         d = 65535;
      return d;
   endfunction

   // leading gap, either anywhere or close to the repeat threshold
   function automatic int gap_dur();
      int d;
      if ($urandom_range(1) == 1)
         d = int'($urandom_range(0, 65535));
      else
         d = int'(repeat_cfg) + int'($urandom_range(0, 4)) - 2;
      if (d < 0)
         d = 0;
      if (d > 65535)
         d = 65535;
      return d;
   endfunction

   // one frame: gap, header mark and space, data marks split by spaces, optional end
   task automatic add_frame(input int nbits, input bit close_it);
      int i;
      push_pulse(ACT_GAP, gap_dur());
      push_pulse(any_label(), pulse_dur(4, 1'b1));
      push_pulse(any_label(), pulse_dur(1, 1'b0));
      for (i = 0; i < nbits; i++) begin
         push_pulse(any_label(), pulse_dur(int'($urandom_range(1, 2)), 1'b1));
         if (i < nbits - 1)
            push_pulse(any_label(), pulse_dur(1, 1'b0));
      end
      if (close_it)
         push_pulse(ACT_END, int'($urandom_range(0, 65535)));
   endtask

   task automatic add_random_stretch();
      int pick, i, n;
      pick = int'($urandom_range(99));
      if (pick < 70) begin
         case ($urandom_range(2))
            0:       add_frame(12, 1'b1);
            1:       add_frame(15, 1'b1);
            default: add_frame(20, 1'b1);
         endcase
      end else if (pick < 80) begin
         add_frame(int'($urandom_range(0, 24)), 1'b1);
      end else if (pick < 84) begin
         // overlong frame runs into the position ceiling
         add_frame(int'($urandom_range(31, 40)), 1'b1);
      end else if (pick < 92) begin
         n = int'($urandom_range(1, 4));
         for (i = 0; i < n; i++)
            push_pulse(any_action(), int'($urandom_range(0, 65535)));
      end else begin
         // frame cut short; a later gap drops it unless a stray end beat closes it first
         add_frame(int'($urandom_range(0, 20)), 1'b0);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_UNIT:   unit_cfg   = UNIT_W'(value);
         CSR_TOL:    tol_cfg    = TOL_W'(value);
         CSR_EXCESS: excess_cfg = EXCESS_W'(value);
         default:    repeat_cfg = GAP_W'(value);
      endcase
   endtask

   task automatic apply_setting(input int unit, input int tol, input int excess, input int gap);
      write_reg(CSR_UNIT, unit);
      write_reg(CSR_TOL, tol);
      write_reg(CSR_EXCESS, excess);
      write_reg(CSR_REPEAT, gap);
   endtask

   // block is idle once every beat is in, every result out and the pipe has flushed
   task automatic wait_idle();
      while (pulses_taken != pulses_queued || frame_result_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int s;
      int stop_at;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (s = 0; s < 6; s++) begin
         if (s > 0) begin
            wait_idle();
            case (s)
               1:       apply_setting(1, 0, 0, 0);
               2:       apply_setting(255, 99, 255, 65535);
               3:       apply_setting(37, 127, 5, 1500);
               4:       apply_setting(8, 10, 1, 300);
               default: apply_setting(200, 50, 0, 40000);
            endcase
         end
         case (s / 2)
            0: begin
               req_idle_pct = 32;
               rsp_idle_pct = 87;
            end
            1: begin
               req_idle_pct = 87;
               rsp_idle_pct = 32;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         if (s == 0) begin
            // beats with no frame open are dropped
            push_pulse(ACT_END, 0);
            push_pulse(ACT_MARK, 50);
            push_pulse(ACT_SPACE, 65535);
            // frame closed before any header mark
            push_pulse(ACT_GAP, 0);
            push_pulse(ACT_END, 0);
            // good header mark only, bad length
            push_pulse(ACT_GAP, 65535);
            push_pulse(ACT_MARK, 50);
            push_pulse(ACT_END, 65535);
            // header mark under the space label, bad header space, reported as bad length
            push_pulse(ACT_GAP, 899);
            push_pulse(ACT_SPACE, 50);
            push_pulse(ACT_MARK, 65535);
            push_pulse(ACT_END, 0);
            // gap while a frame is open restarts it
            push_pulse(ACT_GAP, 900);
            push_pulse(ACT_MARK, 0);
            push_pulse(ACT_GAP, 901);
            push_pulse(ACT_MARK, 50);
            push_pulse(ACT_SPACE, 10);
            push_pulse(ACT_SPACE, 26);
            push_pulse(ACT_MARK, 10);
            push_pulse(ACT_END, 0);
         end

         stop_at = pulses_queued + STRETCH_PULSES;
         while (pulses_queued < stop_at)
            add_random_stretch();
      end

      wait_idle();
      if (frame_result_q.size() != 0)
         failures++;
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/sirc_pkg.sv
src/sirc_match.sv
src/sirc_ir_frame_decoder.sv
sim/sirc_ir_frame_decoder_tb.sv
